// File: design/key_tone_generator_vibrato_core_macros.svh
// Assertion helpers for the port checker file
`ifndef KEY_TONE_GENERATOR_VIBRATO_CORE_MACROS_SVH
`define KEY_TONE_GENERATOR_VIBRATO_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define KTV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KTV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ktv_pkg.sv
`timescale 1ns / 1ps
package ktv_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned RANGE_W  = 10;
	localparam int unsigned STEP_W   = 8;
	localparam int unsigned NOTE_N   = 13;

	// item kinds carried on tuser
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CHAR_W-1:0] KEY_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] KEY_VIB   = 8'h76;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1911;
	localparam logic [RANGE_W-1:0]  RANGE_RST  = 10'd210;
	localparam logic [STEP_W-1:0]   STEP_RST   = 8'd10;

	// register map, byte addresses
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_RANGE = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_STEP  = 3'd4;

	// a w s e d f t g z h u j k
	localparam logic [CHAR_W-1:0] NOTE_KEYS [NOTE_N] = '{
		8'h61, 8'h77, 8'h73, 8'h65, 8'h64, 8'h66, 8'h74,
		8'h67, 8'h7a, 8'h68, 8'h75, 8'h6a, 8'h6b
	};
	// 1e6/f - 1
	localparam logic [PERIOD_W-1:0] NOTE_PERIODS [NOTE_N] = '{
		16'd4423, 16'd3609, 16'd3400, 16'd3214, 16'd3029, 16'd2864, 16'd2701,
		16'd2550, 16'd2408, 16'd2271, 16'd2144, 16'd2023, 16'd1911
	};

	typedef struct packed {
		logic [RANGE_W-1:0] sweep_range;
		logic [STEP_W-1:0]  sweep_step;
	} cfg_t;

	typedef struct packed {
		logic                hit;
		logic [PERIOD_W-1:0] period;
	} note_t;

	// packed from the lowest bit up: pin, period, running, vibrato
	typedef struct packed {
		logic                vibrato_on;
		logic                timer_running;
		logic [PERIOD_W-1:0] period_value;
		logic                pin_level;
	} result_t;

	function automatic note_t note_lookup(input logic [CHAR_W-1:0] c);
		note_t n;
		n.hit    = 1'b0;
		n.period = '0;
		for (int i = 0; i < NOTE_N; i++) begin
			if (c == NOTE_KEYS[i]) begin
				n.hit    = 1'b1;
				n.period = NOTE_PERIODS[i];
			end
		end
		return n;
	endfunction

endpackage

// File: design/ktv_apb_regs.sv
`timescale 1ns / 1ps
module ktv_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ktv_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output ktv_pkg::cfg_t               cfg
);
	import ktv_pkg::*;

	logic [RANGE_W-1:0] range_q;
	logic [STEP_W-1:0]  step_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RST;
			step_q  <= STEP_RST;
		end else if (wr_en) begin
			if (paddr == ADDR_RANGE) range_q <= pwdata[RANGE_W-1:0];
			if (paddr == ADDR_STEP)  step_q  <= pwdata[STEP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_RANGE) prdata = {{(32-RANGE_W){1'b0}}, range_q};
		else if (paddr == ADDR_STEP) prdata = {{(32-STEP_W){1'b0}}, step_q};
	end

	assign cfg.sweep_range = range_q;
	assign cfg.sweep_step  = step_q;

endmodule

// File: design/ktv_tone_engine.sv
`timescale 1ns / 1ps
module ktv_tone_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step_en,
	input  logic                       op,
	input  logic [ktv_pkg::CHAR_W-1:0] key_char,
	input  ktv_pkg::cfg_t              cfg,
	output ktv_pkg::result_t           result
);
	import ktv_pkg::*;

	logic [PERIOD_W-1:0] tick_q, tick_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic [PERIOD_W-1:0] base_q, base_d;
	logic                running_q, running_d;
	logic                vib_q, vib_d;
	logic                up_q, up_d;
	logic                pin_q, pin_d;
	note_t               note;
	logic [PERIOD_W:0]   upper_sum;
	logic [PERIOD_W:0]   lower_sum;

	assign note = note_lookup(key_char);
	// p < b + r, and p > b - r rewritten as p + r > b so no sign is needed
	assign upper_sum = {1'b0, base_q} + {{(PERIOD_W+1-RANGE_W){1'b0}}, cfg.sweep_range};
	assign lower_sum = {1'b0, period_q} + {{(PERIOD_W+1-RANGE_W){1'b0}}, cfg.sweep_range};

	always_comb begin
		tick_d    = tick_q;
		period_d  = period_q;
		base_d    = base_q;
		running_d = running_q;
		vib_d     = vib_q;
		up_d      = up_q;
		pin_d     = pin_q;
		if (op == OP_KEY) begin
			if (note.hit) begin
				running_d = 1'b1;
				period_d  = note.period;
				base_d    = note.period;
			end else if (key_char == KEY_SPACE) begin
				running_d = 1'b0;
				pin_d     = 1'b0;
			end else if (key_char == KEY_VIB) begin
				vib_d = !vib_q;
			end
		end else if (running_q) begin
			if (tick_q == period_q) begin
				tick_d = '0;
				pin_d  = !pin_q;
				if (vib_q) begin
					if (up_q) begin
						if ({1'b0, period_q} < upper_sum)
							period_d = period_q + {{(PERIOD_W-STEP_W){1'b0}}, cfg.sweep_step};
						else
							up_d = 1'b0;
					end else begin
						if (lower_sum > {1'b0, base_q})
							period_d = period_q - {{(PERIOD_W-STEP_W){1'b0}}, cfg.sweep_step};
						else
							up_d = 1'b1;
					end
				end
			end else begin
				tick_d = tick_q + {{(PERIOD_W-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			period_q  <= PERIOD_RST;
			base_q    <= '0;
			running_q <= 1'b1;
			vib_q     <= 1'b0;
			up_q      <= 1'b1;
			pin_q     <= 1'b0;
		end else if (step_en) begin
			tick_q    <= tick_d;
			period_q  <= period_d;
			base_q    <= base_d;
			running_q <= running_d;
			vib_q     <= vib_d;
			up_q      <= up_d;
			pin_q     <= pin_d;
		end
	end

	assign result.pin_level     = pin_d;
	assign result.period_value  = period_d;
	assign result.timer_running = running_d;
	assign result.vibrato_on    = vib_d;

endmodule

// File: design/key_tone_generator_vibrato_core.sv
`timescale 1ns / 1ps
// An accepted request moves from the input register to the result register, which drives m_tvalid.
// Throughput: one request per cycle; the tone state updates in a single pass from the
// input register to the result register, so back-to-back ticks stall only while m_tready is low.
// Reset (arst_n low, asynchronous): pipeline empty, period 1911, timer running, pin low,
// vibrato off, sweep_range 210, sweep_step 10.
module key_tone_generator_vibrato_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] key_char
	input  logic                        s_tuser,  // [0] op
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,  // [0] pin_level, [16:1] period_value,
	                                              // [17] timer_running, [18] vibrato_on
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ktv_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ktv_pkg::*;

	cfg_t                cfg;
	result_t             result;
	logic                valid_s1;
	logic                op_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                out_valid_q;
	result_t             out_q;
	logic                out_adv;
	logic                s1_adv;

	assign out_adv  = !out_valid_q || m_tready;
	assign s1_adv   = valid_s1 && out_adv;
	assign s_tready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) out_q <= result;
	end

	ktv_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ktv_tone_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (s1_adv),
		.op       (op_s1),
		.key_char (char_s1),
		.cfg      (cfg),
		.result   (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24-$bits(result_t)){1'b0}}, out_q};

endmodule

// File: design/ktv_port_chk.sv
`timescale 1ns / 1ps
`include "key_tone_generator_vibrato_core_macros.svh"
module ktv_port_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// stalled result holds
	`KTV_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a stopped timer always leaves the pin low
	`KTV_ASSERT_IMP(a_stop_pin_low, clk, arst_n, m_tvalid && !m_tdata[17], !m_tdata[0], "pin high while timer stopped")

	// a free downstream never holds off the input side
	`KTV_ASSERT_IMP(a_no_stall, clk, arst_n, m_tready, s_tready, "input stalled with output free")

	// padding bits stay clear
	`KTV_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[23:19] == 5'd0, "padding bits set")

endmodule

bind key_tone_generator_vibrato_core ktv_port_chk u_port_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import ktv_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam logic [7:0] NOTE_CHARS [13] = '{
		"a", "w", "s", "e", "d", "f", "t", "g", "z", "h", "u", "j", "k"
	};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;  // [7:0] key_char
	logic                s_tuser  = OP_KEY;  // [0] op
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [23:0]         m_tdata;  // [0] pin_level, [16:1] period_value, [17] timer_running,
	                               // [18] vibrato_on
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	bit          idle_on  = 1'b1;
	bit          hold_req = 1'b0;
	int unsigned quiet_cycles = 0;

	class tone_tracker;
		logic [RANGE_W-1:0]  sweep_range;
		logic [STEP_W-1:0]   sweep_step;
		logic [PERIOD_W-1:0] tick_count;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] base_period;
		bit                  running;
		bit                  vibrato;
		bit                  sweep_up;
		bit                  pin;
		result_t             expected_tone [$];
		int unsigned         errors;

		function new();
			sweep_range = RANGE_RST;
			sweep_step  = STEP_RST;
			tick_count  = '0;
			period      = PERIOD_RST;
			base_period = '0;
			running     = 1'b1;
			vibrato     = 1'b0;
			sweep_up    = 1'b1;
			pin         = 1'b0;
			errors      = 0;
		endfunction

		function void set_reg(logic [PADDR_W-1:0] addr, logic [31:0] val);
			if (addr == ADDR_RANGE)
				sweep_range = val[RANGE_W-1:0];
			else if (addr == ADDR_STEP)
				sweep_step = val[STEP_W-1:0];
		endfunction

		function bit key_period(logic [7:0] ch, output logic [PERIOD_W-1:0] p);
			key_period = 1'b1;
			case (ch)
				"a": p = 16'd4423;
				"w": p = 16'd3609;
				"s": p = 16'd3400;
				"e": p = 16'd3214;
				"d": p = 16'd3029;
				"f": p = 16'd2864;
				"t": p = 16'd2701;
				"g": p = 16'd2550;
				"z": p = 16'd2408;
				"h": p = 16'd2271;
				"u": p = 16'd2144;
				"j": p = 16'd2023;
				"k": p = 16'd1911;
				default: begin
					p = '0;
					key_period = 1'b0;
				end
			endcase
		endfunction

		function void compare_hit();
			int p, b, r;
			p = period;
			b = base_period;
			r = sweep_range;
			tick_count = '0;
			pin = !pin;
			if (!vibrato)
				return;
			// bounds are signed and wider than the period, the period itself wraps
			if (sweep_up) begin
				if (p < b + r)
					period = period + sweep_step;
				else
					sweep_up = 1'b0;
			end else begin
				if (p > b - r)
					period = period - sweep_step;
				else
					sweep_up = 1'b1;
			end
		endfunction

		function void take_request(logic op, logic [7:0] ch);
			logic [PERIOD_W-1:0] np;
			result_t             res;
			if (op == OP_KEY) begin
				if (key_period(ch, np)) begin
					running     = 1'b1;
					period      = np;
					base_period = np;
				end else if (ch == KEY_SPACE) begin
					running = 1'b0;
					pin     = 1'b0;
				end else if (ch == KEY_VIB) begin
					vibrato = !vibrato;
				end
			end else if (running) begin
				if (tick_count == period)
					compare_hit();
				else
					tick_count = tick_count + 16'd1;
			end
			res.pin_level     = pin;
			res.period_value  = period;
			res.timer_running = running;
			res.vibrato_on    = vibrato;
			expected_tone.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_tone.size() == 0) begin
				$error("unexpected result %0h with no request outstanding", got);
				errors++;
				return;
			end
			want = expected_tone.pop_front();
			if (got.pin_level !== want.pin_level) begin
				$error("pin_level: expected %0d, got %0d", want.pin_level, got.pin_level);
				errors++;
			end
			if (got.period_value !== want.period_value) begin
				$error("period_value: expected %0d, got %0d", want.period_value,
					got.period_value);
				errors++;
			end
			if (got.timer_running !== want.timer_running) begin
				$error("timer_running: expected %0d, got %0d", want.timer_running,
					got.timer_running);
				errors++;
			end
			if (got.vibrato_on !== want.vibrato_on) begin
				$error("vibrato_on: expected %0d, got %0d", want.vibrato_on, got.vibrato_on);
				errors++;
			end
		endfunction
	endclass

	tone_tracker tracker;

	key_tone_generator_vibrato_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(result_t'(m_tdata[18:0]));
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_req(input logic op, input logic [7:0] ch);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_request(op, ch);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.expected_tone.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.set_reg(addr, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [RANGE_W-1:0] rng, input logic [STEP_W-1:0] stp);
		drain();
		apb_write(ADDR_RANGE, 32'(rng));
		apb_write(ADDR_STEP, 32'(stp));
	endtask

	task automatic tick_run(input int n, input bit hold);
		for (int i = 0; i < n; i++) begin
			if (hold && i == n / 2)
				hold_req = 1'b1;
			send_req(OP_TICK, 8'($urandom));
		end
	endtask

	task automatic sweep_phase(input logic [RANGE_W-1:0] rng, input logic [STEP_W-1:0] stp,
			input logic [7:0] note, input int n, input bit hold);
		set_config(rng, stp);
		if (!tracker.vibrato)
			send_req(OP_KEY, KEY_VIB);
		send_req(OP_KEY, note);
		tick_run(n, hold);
	endtask

	task automatic random_item();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4)
			send_req(OP_TICK, 8'($urandom));
		else if (kind < 7)
			send_req(OP_KEY, NOTE_CHARS[$urandom_range(0, 12)]);
		else if (kind == 7)
			send_req(OP_KEY, KEY_SPACE);
		else if (kind == 8)
			send_req(OP_KEY, KEY_VIB);
		else
			send_req(OP_KEY, 8'($urandom));
	endtask

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// vibrato before any note: the sweep runs around a zero base
		set_config(10'd1023, 8'd255);
		send_req(OP_KEY, KEY_VIB);
		tick_run(150, 1'b0);

		send_req(OP_KEY, 8'h00);
		send_req(OP_KEY, 8'hFF);
		foreach (NOTE_CHARS[i])
			send_req(OP_KEY, NOTE_CHARS[i]);
		send_req(OP_KEY, KEY_SPACE);
		send_req(OP_TICK, 8'hFF);
		send_req(OP_TICK, 8'h00);
		send_req(OP_KEY, "b");
		send_req(OP_KEY, KEY_VIB);
		send_req(OP_KEY, KEY_VIB);
		send_req(OP_KEY, "k");
		send_req(OP_TICK, 8'h00);
		send_req(OP_TICK, 8'hFF);

		// note changes keep the running count
		if (tracker.vibrato)
			send_req(OP_KEY, KEY_VIB);
		send_req(OP_KEY, "a");
		send_req(OP_KEY, "k");
		tick_run(40, 1'b0);

		sweep_phase(RANGE_RST, STEP_RST, "k", 60, 1'b0);
		sweep_phase(10'd0, 8'd0, "h", 40, 1'b0);
		sweep_phase(10'd1023, 8'd255, "a", 120, 1'b1);
		sweep_phase(10'd20, 8'd200, "j", 40, 1'b0);
		idle_on = 1'b0;
		sweep_phase(10'($urandom_range(0, 300)), 8'($urandom_range(1, 255)),
			NOTE_CHARS[$urandom_range(0, 12)], 60, 1'b0);
		idle_on = 1'b1;

		set_config(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
		repeat (300) random_item();
		idle_on = 1'b0;
		repeat (100) random_item();

		drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_tone.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/ktv_pkg.sv
design/ktv_apb_regs.sv
design/ktv_tone_engine.sv
design/key_tone_generator_vibrato_core.sv
design/ktv_port_chk.sv
tb/sv/tb.sv
